[sv/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// This package holds the controller states, the result status codes, and the
// command and status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

   // request kinds carried on req_tuser
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   // result status carried on rsp_tuser
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CMP,
      ST_DEQ_RD,
      ST_DEQ_POP,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request, set up scan index and result status
      logic rd_scan;   // read the entry just below the scan index
      logic rd_head;   // read the front entry
      logic wr_new;    // write the new entry at the scan index
      logic wr_shift;  // move the read entry up one place
      logic pop;       // retire the front entry
      logic load_rsp;  // move the result into the output register
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic full;
      logic idx_zero;
      logic key_le;
      logic out_free;
   } ctrl_sts_type;

endpackage

[sv/sorted_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: sorted list priority queue
// Holds up to CAPACITY entries sorted by signed priority, lowest first, equal
// priorities in arrival order. Each request gives one response with a status.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  tuser command, tdata data+priority
//   rsp      out        rsp_tvalid/rsp_tready  tuser status, tdata data+count
//
// - enqueue: the insertion scan alternates one registered read of the entry
//   store (scan step) with one write (compare step), moving entries up one
//   place until the new entry is written; dequeue reads, then retires the front
//   entry; an empty dequeue or a full enqueue goes straight to the response step
// - reset clears the entry count, head pointer and response valid; the store
//   itself is not cleared
// - a stalled response holds the controller in its response step; the next
//   request is taken once the response moves into the output register
//
module sorted_priority_queue_core
   import spq_pkg::*;
#(
   parameter int CAPACITY       = 16,
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] data_in, [47:32] priority_req
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] data_out, [36:32] entry_count, zero fill
   output logic  [1:0] rsp_tuser    // [1:0] status
);

   ctrl_cmd_type cmd;
   ctrl_sts_type sts;
   logic  [31:0] rsp_data;
   logic   [4:0] rsp_count;

   // controller: sequences each transfer through scan, dequeue and response
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: circular sorted store, counters and output register
   spq_datapath #(
      .CAPACITY       (CAPACITY),
      .DATA_WIDTH     (DATA_WIDTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_command  (req_tuser),
      .req_data     (req_tdata[31:0]),
      .req_priority (req_tdata[47:32]),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_data     (rsp_data),
      .rsp_status   (rsp_tuser),
      .rsp_count    (rsp_count)
   );

   // pack response fields, lowest field first
   assign rsp_tdata = {3'b000, rsp_count, rsp_data};

endmodule

[sv/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl: controller of the sorted priority queue
// Sequences enqueue insertion scans, dequeue reads and result handoff.
// ----------------------------------------------------------------------------
module spq_ctrl
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tuser,
   output logic         req_tready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == CMD_DEQUEUE) begin
                  state_in = sts.empty ? ST_RESP : ST_DEQ_RD;
               end else begin
                  state_in = sts.full ? ST_RESP : ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            state_in = sts.idx_zero ? ST_RESP : ST_CMP;
         end
         ST_CMP: begin
            state_in = sts.key_le ? ST_RESP : ST_SCAN;
         end
         ST_DEQ_RD: begin
            state_in = ST_DEQ_POP;
         end
         ST_DEQ_POP: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_SCAN: begin
            cmd.wr_new  = sts.idx_zero;
            cmd.rd_scan = !sts.idx_zero;
         end
         ST_CMP: begin
            cmd.wr_new   = sts.key_le;
            cmd.wr_shift = !sts.key_le;
         end
         ST_DEQ_RD: begin
            cmd.rd_head = 1'b1;
         end
         ST_DEQ_POP: begin
            cmd.pop = 1'b1;
         end
         ST_RESP: begin
            cmd.load_rsp = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[sv/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath: entry store and result registers of the sorted priority queue
// Entries sit in a circular buffer in sorted order; insertion moves entries up
// one place a step, dequeue advances the head.
// ----------------------------------------------------------------------------
module spq_datapath
   import spq_pkg::*;
#(
   parameter int CAPACITY       = 16,
   parameter int DATA_WIDTH     = 32,
   parameter int PRIORITY_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_command,
   input  logic        [31:0] req_data,
   input  logic        [15:0] req_priority,
   input  ctrl_cmd_type       cmd,
   output ctrl_sts_type       sts,
   input  logic               rsp_tready,
   output logic               rsp_tvalid,
   output logic        [31:0] rsp_data,
   output logic         [1:0] rsp_status,
   output logic         [4:0] rsp_count
);

   localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW  = $clog2(CAPACITY + 1);
   localparam int EW  = PRIORITY_WIDTH + DATA_WIDTH;
   localparam int DXW = DATA_WIDTH + 32;
   localparam int PXW = PRIORITY_WIDTH + 16;
   localparam int CXW = CW + 5;
   localparam logic [AW:0] CAP_EXT = (AW + 1)'(CAPACITY);
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
   localparam logic [PRIORITY_WIDTH-1:0] SIGN_FLIP =
      PRIORITY_WIDTH'(1) << (PRIORITY_WIDTH - 1);

   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
      logic [AW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= CAP_EXT) begin
         s = s - CAP_EXT;
      end
      return s[AW-1:0];
   endfunction

   logic [EW-1:0] mem [CAPACITY];
   logic [EW-1:0] rd_data_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [EW-1:0] new_ff, new_in;
   logic   [31:0] res_data_ff, res_data_in;
   logic    [1:0] res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic   [31:0] rsp_data_ff, rsp_data_in;
   logic    [1:0] rsp_status_ff, rsp_status_in;
   logic    [4:0] rsp_count_ff, rsp_count_in;

   logic [DXW-1:0]            data_wide;
   logic [PXW-1:0]            prio_wide;
   logic [DATA_WIDTH+31:0]    out_wide;
   logic [CXW-1:0]            count_wide;
   logic [CW-1:0]             idx_dec;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic [EW-1:0]             wr_data;
   logic                      mem_we;
   logic [PRIORITY_WIDTH-1:0] key_rd;
   logic [PRIORITY_WIDTH-1:0] key_new;

   assign data_wide  = DXW'(req_data);
   assign prio_wide  = PXW'(req_priority);
   assign out_wide   = (DATA_WIDTH + 32)'(rd_data_ff[DATA_WIDTH-1:0]);
   assign count_wide = CXW'(count_ff);
   assign idx_dec    = idx_ff - CW'(1);

   // order key: sign bit flipped so unsigned compare gives signed order
   assign key_rd  = rd_data_ff[EW-1:DATA_WIDTH] ^ SIGN_FLIP;
   assign key_new = new_ff[EW-1:DATA_WIDTH] ^ SIGN_FLIP;

   assign rd_addr = (cmd.rd_head || !cmd.rd_scan) ? head_ff
                                                  : wrap_add(head_ff, idx_dec[AW-1:0]);
   assign wr_addr = wrap_add(head_ff, idx_ff[AW-1:0]);
   assign wr_data = cmd.wr_new ? new_ff : rd_data_ff;
   assign mem_we  = cmd.wr_new || cmd.wr_shift;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      count_in      = count_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      res_data_in   = res_data_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      if (cmd.capture) begin
         idx_in      = count_ff;
         new_in      = {prio_wide[PRIORITY_WIDTH-1:0], data_wide[DATA_WIDTH-1:0]};
         res_data_in = '0;
         if (req_command == CMD_DEQUEUE) begin
            res_status_in = (count_ff == '0) ? STATUS_EMPTY : STATUS_DONE;
         end else begin
            res_status_in = (count_ff >= CAP_CNT) ? STATUS_FULL : STATUS_DONE;
         end
      end
      if (cmd.wr_new) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.wr_shift) begin
         idx_in = idx_dec;
      end
      if (cmd.pop) begin
         res_data_in = out_wide[31:0];
         count_in    = count_ff - CW'(1);
         head_in     = wrap_add(head_ff, AW'(1));
      end

      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = res_data_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = count_wide[4:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      new_ff        <= new_in;
      res_data_ff   <= res_data_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign sts.empty    = (count_ff == '0);
   assign sts.full     = (count_ff >= CAP_CNT);
   assign sts.idx_zero = (idx_ff == '0);
   assign sts.key_le   = (key_rd <= key_new);
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.wr_new |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not grow the entry count");

   a_pop_advances: assert property (@(posedge clock) disable iff (reset)
      !reset && cmd.pop |=> count_ff == $past(count_ff) - CW'(1)
                            && head_ff != $past(head_ff))
      else $error("dequeue did not retire the front entry");

   a_no_write_on_pop: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && cmd.pop))
      else $error("store written while retiring an entry");

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sorted_priority_queue_core
// Drives enqueue and dequeue transfers with bursty valid and a stalling
// receiver. A shadow sorted list predicts every response, which is compared
// field by field in arrival order. A directed table covers empty, full, ties
// and extreme values before a long randomized run.
// ----------------------------------------------------------------------------
module testbench
   import spq_pkg::*;
();

   localparam int ENTRY_CAPACITY = 16;
   localparam int RANDOM_ITEMS   = 1325;
   localparam int PAUSE_AT       = 700;   // sender waits for every outstanding response here
   localparam int HOLD_AT        = 300;   // receiver holds off from here
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 60;
   localparam int STALL_LIMIT    = 3000;  // cycles without any transfer
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [31:0] data_out;
      logic [1:0]  status;
      logic [4:0]  count;
   } pq_result_type;

   typedef struct {
      logic               cmd;
      logic [31:0]        data;
      logic signed [15:0] prio;
      bit                 typed;       // response written into the table
      pq_result_type      typed_rsp;
   } pq_request_type;

   typedef struct {
      logic [31:0]        data;
      logic signed [15:0] prio;
   } pq_entry_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // [31:0] data_in, [47:32] priority_req
   logic        req_tuser  = CMD_ENQUEUE;   // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] data_out, [36:32] entry_count
   logic  [1:0] rsp_tuser;         // [1:0] status

   pq_request_type request_q[$];      // whole stimulus, directed rows first
   pq_result_type  pending_rsp_q[$];  // predicted responses not yet seen
   pq_entry_type   sorted_entries[$]; // shadow of the queue contents

   int req_count, rsp_count, mismatches;
   int enq_count, deq_count, done_count, empty_count, full_count, peak_count;
   int stall_cycles;

   sorted_priority_queue_core #(
      .CAPACITY       (ENTRY_CAPACITY),
      .DATA_WIDTH     (32),
      .PRIORITY_WIDTH (16)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // shadow queue update: returns the response one request should give
   function automatic pq_result_type predict_queue_op(input logic cmd,
                                                      input logic [31:0] data,
                                                      input logic signed [15:0] prio);
      pq_result_type r;
      pq_entry_type  e;
      int            pos;
      r.data_out = '0;
      r.status   = STATUS_DONE;
      if (cmd == CMD_DEQUEUE) begin
         if (sorted_entries.size() == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            e = sorted_entries.pop_front();
            r.data_out = e.data;
         end
      end else if (sorted_entries.size() >= ENTRY_CAPACITY) begin
         r.status = STATUS_FULL;
      end else begin
         // new entry goes behind every entry of equal priority
         pos = 0;
         while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio)
            pos++;
         e.data = data;
         e.prio = prio;
         sorted_entries.insert(pos, e);
      end
      r.count = 5'(sorted_entries.size());
      return r;
   endfunction

   task automatic add_request(input logic cmd, input logic [31:0] data,
                              input logic [15:0] prio, input bit typed,
                              input logic [31:0] exp_data, input logic [1:0] exp_status,
                              input logic [4:0] exp_count);
      pq_request_type it;
      it.cmd                = cmd;
      it.data               = data;
      it.prio               = prio;
      it.typed              = typed;
      it.typed_rsp.data_out = exp_data;
      it.typed_rsp.status   = exp_status;
      it.typed_rsp.count    = exp_count;
      request_q.push_back(it);
   endtask

   // ------------------------------------------------------------------------
   // request side: directed table, random segments, bursty valid
   // ------------------------------------------------------------------------
   initial begin : drive_requests
      int          burst_left, gap, seg_left, enq_pct;
      logic        cmd;
      logic [31:0] data;
      logic [15:0] prio;

      //          cmd          data          prio      typed data  status        count
      add_request(CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1, 32'h0, STATUS_EMPTY, 5'd0);
      add_request(CMD_ENQUEUE, 32'h7fff_ffff, 16'h7fff, 1, 32'h0, STATUS_DONE,  5'd1);
      add_request(CMD_ENQUEUE, 32'h8000_0000, 16'h8000, 1, 32'h0, STATUS_DONE,  5'd2);
      add_request(CMD_ENQUEUE, 32'h0000_0000, 16'h0000, 1, 32'h0, STATUS_DONE,  5'd3);
      add_request(CMD_ENQUEUE, 32'hffff_ffff, 16'hffff, 1, 32'h0, STATUS_DONE,  5'd4);
      add_request(CMD_ENQUEUE, 32'h0000_0001, 16'h0000, 1, 32'h0, STATUS_DONE,  5'd5);
      // most negative priority leaves first, then -1, then the tie in order
      add_request(CMD_DEQUEUE, 32'h1234_5678, 16'h1111, 1, 32'h8000_0000, STATUS_DONE, 5'd4);
      add_request(CMD_DEQUEUE, 32'hfedc_ba98, 16'h2222, 1, 32'hffff_ffff, STATUS_DONE, 5'd3);
      add_request(CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 1, 32'h0000_0000, STATUS_DONE, 5'd2);
      // fill to capacity: front, back, middle and tied insert positions
      add_request(CMD_ENQUEUE, 32'ha5a5_a5a5, 16'h8000, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h5a5a_5a5a, 16'h7fff, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h0000_0002, 16'h0000, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'hffff_fffe, 16'hffff, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h8000_0001, 16'h8000, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h7fff_fffe, 16'h0001, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h1234_5678, 16'h7ffe, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h9abc_def0, 16'h1234, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h0f0f_0f0f, 16'hedcc, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'hf0f0_f0f0, 16'h8000, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h3333_3333, 16'h7fff, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'hcccc_cccc, 16'h0000, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'h00ff_00ff, 16'h4000, 0, 32'h0, STATUS_DONE, 5'd0);
      add_request(CMD_ENQUEUE, 32'hff00_ff00, 16'hc000, 0, 32'h0, STATUS_DONE, 5'd0);
      // full queue drops the entry
      add_request(CMD_ENQUEUE, 32'hdead_0001, 16'h8000, 1, 32'h0, STATUS_FULL, 5'd16);
      add_request(CMD_DEQUEUE, 32'h0000_0000, 16'h0000, 0, 32'h0, STATUS_DONE, 5'd0);

      // random part: segments leaning to enqueue, dequeue or neither, so the
      // queue wanders between empty and full
      seg_left = 0;
      enq_pct  = 50;
      repeat (RANDOM_ITEMS) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
               0: enq_pct = 15;
               1: enq_pct = 50;
               default: enq_pct = 85;
            endcase
         end
         seg_left--;
         cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQUEUE : CMD_DEQUEUE;
         case ($urandom_range(0, 15))
            0: data = 32'h8000_0000;
            1: data = 32'h7fff_ffff;
            2: data = 32'h0000_0000;
            3: data = 32'hffff_ffff;
            default: data = $urandom;
         endcase
         // narrow band gives many ties
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: prio = 16'($urandom_range(0, 8) - 4);
            5, 6, 7: prio = 16'($urandom);
            8: prio = 16'h8000;
            default: prio = 16'h7fff;
         endcase
         add_request(cmd, data, prio, 0, 32'h0, STATUS_DONE, 5'd0);
      end

      do @(posedge clock); while (reset);

      burst_left = $urandom_range(1, 40);
      foreach (request_q[i]) begin
         if (i == PAUSE_AT) begin
            // let every outstanding response come back before going on
            req_tvalid <= 1'b0;
            do @(posedge clock); while (pending_rsp_q.size() != 0);
         end
         req_tvalid <= 1'b1;
         req_tuser  <= request_q[i].cmd;
         req_tdata  <= {request_q[i].prio, request_q[i].data};
         do @(posedge clock); while (!req_tready);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 60);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending_rsp_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests (%0d enqueue, %0d dequeue), %0d responses checked",
               req_count, enq_count, deq_count, rsp_count);
      $display("responses: %0d done, %0d empty, %0d full; deepest occupancy %0d",
               done_count, empty_count, full_count, peak_count);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // response side: stall pattern of its own plus one long hold-off
   // ------------------------------------------------------------------------
   int  ready_mode, mode_left, hold_left;
   bit  hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         mode_left  <= 0;
         hold_left  <= 0;
         hold_done  <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && req_count >= HOLD_AT) begin
         // long hold-off: the core fills its output stage and stops taking requests
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            mode_left  <= $urandom_range(10, 120);
            ready_mode <= $urandom_range(0, 3);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // transfer monitor: responses checked before the same edge's request is
   // predicted, so an ordering within one edge can't pair them wrongly
   // ------------------------------------------------------------------------
   pq_result_type got_rsp, exp_rsp;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.data_out = rsp_tdata[31:0];
            got_rsp.count    = rsp_tdata[36:32];
            got_rsp.status   = rsp_tuser;
            rsp_count++;
            case (got_rsp.status)
               STATUS_DONE:  done_count++;
               STATUS_EMPTY: empty_count++;
               STATUS_FULL:  full_count++;
               default: ;
            endcase
            if (int'(got_rsp.count) > peak_count)
               peak_count = int'(got_rsp.count);
            if (pending_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected response: data %h status %0d count %0d",
                           got_rsp.data_out, got_rsp.status, got_rsp.count);
            end else begin
               exp_rsp = pending_rsp_q.pop_front();
               if (got_rsp.data_out !== exp_rsp.data_out ||
                   got_rsp.status   !== exp_rsp.status   ||
                   got_rsp.count    !== exp_rsp.count) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display({"response %0d mismatch: expected data %h status %0d ",
                               "count %0d, got data %h status %0d count %0d"},
                              rsp_count, exp_rsp.data_out, exp_rsp.status,
                              exp_rsp.count, got_rsp.data_out, got_rsp.status,
                              got_rsp.count);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            exp_rsp = predict_queue_op(request_q[req_count].cmd,
                                       request_q[req_count].data,
                                       request_q[req_count].prio);
            if (request_q[req_count].typed)
               exp_rsp = request_q[req_count].typed_rsp;
            if (request_q[req_count].cmd == CMD_ENQUEUE)
               enq_count++;
            else
               deq_count++;
            pending_rsp_q.push_back(exp_rsp);
            req_count++;
         end
      end
   end

   // watchdog: no transfer on either side for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: %0d responses still outstanding", pending_rsp_q.size());
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule
